// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define F2I_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("check failed");
`define F2I_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error("check failed");
`else
`define F2I_ASSERT(lbl, clk, rstn, prop)
`define F2I_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/f2i_pkg.sv -----
`default_nettype none
package f2i_pkg;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [31:0] NUM_RESET = 32'd32767;
    localparam logic [31:0] DEN_RESET = 32'd40;

    localparam logic [7:0] EXP_ALL_ONES = 8'hff;
    localparam logic [7:0] EXP_UNITY    = 8'd150;
    localparam logic [7:0] EXP_DENORM   = 8'd149;
    localparam logic [7:0] SHIFT_LIMIT  = 8'd63;

    localparam int QUO_BITS = 32;
    localparam logic [32:0] QUO_MAX = 33'd2147483647;

    localparam logic CFG_NUM = 1'b0;
    localparam logic CFG_DEN = 1'b1;

    typedef struct packed {
        logic        neg;
        logic [1:0]  status;
        logic [63:0] dvd;
        logic [63:0] dvs;
    } t_div_in;

    typedef struct packed {
        logic        neg;
        logic [1:0]  status;
        logic [63:0] rem;
        logic [63:0] dvs;
        logic [31:0] quo;
    } t_dstage;
endpackage
`default_nettype wire

// ----- rtl/core/f2i_in_if.sv -----
`default_nettype none
interface f2i_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] float_bits;
    modport source (output valid, output float_bits, input ready);
    modport sink (input valid, input float_bits, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/f2i_out_if.sv -----
`default_nettype none
interface f2i_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] int_value;
    logic [1:0]         status;
    modport source (output valid, output int_value, output status, input ready);
    modport sink (input valid, input int_value, input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/f2i_front.sv -----
`default_nettype none
module f2i_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [31:0]     i_num,
    input  wire logic [31:0]     i_den,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [31:0]     i_float_bits,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output f2i_pkg::t_div_in     o_item
);
    import f2i_pkg::*;

    logic [7:0]   expo;
    logic [22:0]  frac;
    logic [23:0]  mant;
    logic [55:0]  prod;
    logic         en_a;
    logic         en_b;

    logic         r_a_valid;
    logic         r_a_neg;
    logic [1:0]   r_a_status;
    logic         r_a_zero;
    logic         r_a_left;
    logic [7:0]   r_a_sh;
    logic [55:0]  r_a_prod;

    logic [7:0]   n_a_sh;
    logic [127:0] wide_l;
    logic [127:0] wide_r;
    logic         r_b_valid;
    t_div_in      r_b_item;
    t_div_in      n_b_item;

    assign expo = i_float_bits[30:23];
    assign frac = i_float_bits[22:0];
    assign mant = {(expo != 8'd0), frac};
    assign prod = 56'(mant) * 56'(i_num);

    assign en_b    = !r_b_valid || i_ready;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;

    always_comb begin
        if (expo >= EXP_UNITY) begin
            n_a_sh = expo - EXP_UNITY;
        end else if (expo == 8'd0) begin
            n_a_sh = EXP_DENORM;
        end else begin
            n_a_sh = EXP_UNITY - expo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_valid;
        end
        if (en_a) begin
            r_a_neg    <= i_float_bits[31];
            r_a_status <= (i_den == 32'd0 || expo == EXP_ALL_ONES) ? ST_INVALID : ST_OK;
            r_a_zero   <= (expo == 8'd0) && (frac == 23'd0);
            r_a_left   <= expo >= EXP_UNITY;
            r_a_sh     <= n_a_sh;
            r_a_prod   <= prod;
        end
    end

    assign wide_l = {72'd0, r_a_prod} << r_a_sh;
    assign wide_r = {96'd0, i_den} << r_a_sh;

    always_comb begin
        n_b_item.neg    = r_a_neg;
        n_b_item.status = r_a_status;
        n_b_item.dvd    = 64'd0;
        n_b_item.dvs    = 64'd1;
        if (r_a_status == ST_OK && !r_a_zero) begin
            if (r_a_left) begin
                if (r_a_sh >= SHIFT_LIMIT || (|wide_l[127:64])) begin
                    n_b_item.status = ST_RANGE;
                end else begin
                    n_b_item.dvd = wide_l[63:0];
                    n_b_item.dvs = {32'd0, i_den};
                end
            end else if (r_a_sh < SHIFT_LIMIT) begin
                if (|wide_r[127:64]) begin
                    n_b_item.status = ST_RANGE;
                end else begin
                    n_b_item.dvd = {8'd0, r_a_prod};
                    n_b_item.dvs = wide_r[63:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
        if (en_b) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;
endmodule
`default_nettype wire

// ----- rtl/core/f2i_div.sv -----
`default_nettype none
module f2i_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire f2i_pkg::t_div_in i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output f2i_pkg::t_dstage     o_item
);
    import f2i_pkg::*;

    logic    r_v [0:QUO_BITS];
    t_dstage r_s [0:QUO_BITS];
    logic    en  [0:QUO_BITS+1];
    t_dstage n_p;
    logic    ovf;

    assign en[QUO_BITS+1] = i_ready;
    assign o_ready = en[0];

    // quotient must fit the bits produced below
    assign ovf = {32'd0, i_item.dvd} >= {i_item.dvs, 32'd0};

    always_comb begin
        n_p.neg    = i_item.neg;
        n_p.status = i_item.status;
        n_p.rem    = i_item.dvd;
        n_p.dvs    = i_item.dvs;
        n_p.quo    = '0;
        if (i_item.status == ST_OK && ovf) begin
            n_p.status = ST_RANGE;
            n_p.rem    = 64'd0;
            n_p.dvs    = 64'd1;
        end
    end

    assign en[0] = !r_v[0] || en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en[0]) begin
            r_v[0] <= i_valid;
        end
        if (en[0]) begin
            r_s[0] <= n_p;
        end
    end

    for (genvar k = 1; k <= QUO_BITS; k++) begin : g_step
        localparam int BIT = QUO_BITS - k;
        logic [95:0] trial;
        logic        take;
        t_dstage     n_s;

        assign en[k] = !r_v[k] || en[k+1];
        assign trial = {32'd0, r_s[k-1].dvs} << BIT;
        assign take  = trial <= {32'd0, r_s[k-1].rem};

        always_comb begin
            n_s = r_s[k-1];
            if (take) begin
                n_s.rem      = r_s[k-1].rem - trial[63:0];
                n_s.quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= r_v[k-1];
            end
            if (en[k]) begin
                r_s[k] <= n_s;
            end
        end
    end

    assign o_valid = r_v[QUO_BITS];
    assign o_item  = r_s[QUO_BITS];
endmodule
`default_nettype wire

// ----- rtl/core/f2i_round.sv -----
`default_nettype none
module f2i_round (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire f2i_pkg::t_dstage i_item,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic signed [31:0]    o_int_value,
    output logic [1:0]            o_status
);
    import f2i_pkg::*;

    logic [64:0]        twice;
    logic [64:0]        dvs_x;
    logic               up;
    logic [32:0]        qr;
    logic [31:0]        mag;
    logic               en;
    logic [1:0]         n_status;
    logic signed [31:0] n_value;
    logic               r_valid;
    logic [1:0]         r_status;
    logic signed [31:0] r_value;

    assign twice = {i_item.rem, 1'b0};
    assign dvs_x = {1'b0, i_item.dvs};
    assign up    = (twice > dvs_x) || (twice == dvs_x && i_item.quo[0]);
    assign qr    = {1'b0, i_item.quo} + 33'(up);
    assign mag   = qr[31:0];

    always_comb begin
        n_status = i_item.status;
        n_value  = '0;
        if (i_item.status == ST_OK) begin
            if (qr > QUO_MAX) begin
                n_status = ST_RANGE;
            end else begin
                n_value = i_item.neg ? $signed(32'd0 - mag) : $signed(mag);
            end
        end
    end

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
        if (en) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_int_value = r_value;
endmodule
`default_nettype wire

// ----- rtl/core/float32_scaled_to_int_rne.sv -----
// Channel  Dir  Beat fields            Handshake
// i_in     in   float_bits[31:0]       valid/ready
// o_out    out  int_value[31:0]/status valid/ready
// cfg      in   i_cfg_idx/i_cfg_data   i_cfg_we, no back-pressure
//
// One beat per cycle sustained while o_out accepts; the stages are decode and
// multiply, shift, quotient range check, 32 restoring divide steps and round.
// Each stage holds its beat under back-pressure and fills bubbles.
// Synchronous active-low reset clears valid bits and loads register defaults.
`default_nettype none
`include "assert_macros.svh"
module float32_scaled_to_int_rne (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    f2i_in_if.sink           i_in,
    f2i_out_if.source        o_out
);
    import f2i_pkg::*;

    logic [31:0] r_num;
    logic [31:0] r_den;
    logic        fr_valid;
    logic        dv_ready;
    t_div_in     fr_item;
    logic        dv_valid;
    logic        rd_ready;
    t_dstage     dv_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= NUM_RESET;
            r_den <= DEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM: r_num <= i_cfg_data;
                CFG_DEN: r_den <= i_cfg_data;
                default: r_num <= r_num;
            endcase
        end
    end

    f2i_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num        (r_num),
        .i_den        (r_den),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_float_bits (i_in.float_bits),
        .o_valid      (fr_valid),
        .i_ready      (dv_ready),
        .o_item       (fr_item)
    );

    f2i_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (dv_ready),
        .i_item  (fr_item),
        .o_valid (dv_valid),
        .i_ready (rd_ready),
        .o_item  (dv_item)
    );

    f2i_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dv_valid),
        .o_ready     (rd_ready),
        .i_item      (dv_item),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_int_value (o_out.int_value),
        .o_status    (o_out.status)
    );

    `F2I_ASSERT_IMP(a_nonok_zero, i_clk, i_rst_n, o_out.valid && o_out.status != ST_OK, o_out.int_value == 32'sd0)
    `F2I_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out.valid, o_out.status == ST_OK || o_out.status == ST_INVALID || o_out.status == ST_RANGE)
    `F2I_ASSERT_IMP(a_ok_in_range, i_clk, i_rst_n, o_out.valid && o_out.status == ST_OK, o_out.int_value != 32'sh80000000)
endmodule
`default_nettype wire
